[hw/rtl/bgr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_pkg
// Types and constants shared by the glyph row renderer modules.
// ----------------------------------------------------------------------------
package bgr_pkg;

    localparam int GLYPH_COUNT     = 95;
    localparam int BITMAP_BYTES    = 4096;
    localparam int MAX_ROWS        = 32;
    localparam int MAX_WIDTH_BYTES = 4;

    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] MSB_BIT    = 8'h80;

    localparam int GLYPH_AW   = $clog2(GLYPH_COUNT);
    localparam int BITMAP_AW  = $clog2(BITMAP_BYTES);
    localparam int DESC_W     = 15;
    localparam int LEN_W      = 13;
    localparam int CURSOR_W   = 13;
    localparam int KW         = $clog2(MAX_WIDTH_BYTES + 1);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int MASK_BYTES = 4;

    // Register word index on the configuration port.
    localparam logic REG_BITMAP_LEN = 1'b0;

    typedef enum logic [1:0] {
        REQ_LOAD_DESC = 2'd0,
        REQ_LOAD_BYTE = 2'd1,
        REQ_DRAW      = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DESC0,
        S_DESC1,
        S_FETCH,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] load_index;
        logic [2:0]  glyph_width_bytes;
        logic [11:0] load_value;
        logic [7:0]  char_code;
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [7:0]  ink_color;
    } in_item_t;

    typedef struct packed {
        logic [10:0] row_x;
        logic [10:0] row_y;
        logic [31:0] pixel_mask;
        logic [7:0]  pixel_color;
        logic        last_row;
    } out_item_t;

    typedef struct packed {
        logic [GLYPH_AW-1:0]  desc_raddr;
        logic [BITMAP_AW-1:0] byte_raddr;
    } mem_rd_t;

endpackage

[hw/rtl/bgr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bgr_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/bgr_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_seq
// Draw sequencer: reads the glyph descriptors, then walks the glyph bytes
// through one shared address adder and assembles one row mask at a time.
// ----------------------------------------------------------------------------
module bgr_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_accept,
    input  bgr_pkg::in_item_t            in_item,
    input  logic [bgr_pkg::LEN_W-1:0]    bitmap_len,
    input  logic [bgr_pkg::DESC_W-1:0]   desc_rdata,
    input  logic [7:0]                   byte_rdata,
    input  logic                         out_free,
    output bgr_pkg::mem_rd_t             mem_rd,
    output logic                         idle,
    output logic                         row_push,
    output bgr_pkg::out_item_t           row
);
    import bgr_pkg::*;

    seq_state_t           state_reg, state_next;
    logic [GLYPH_AW-1:0]  g_reg, g_next;
    logic [10:0]          px_reg, px_next;
    logic [10:0]          py_reg, py_next;
    logic [7:0]           ink_reg, ink_next;
    logic [KW-1:0]        w_reg, w_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [CURSOR_W-1:0]  cursor_reg, cursor_next;
    logic [CURSOR_W-1:0]  stop_reg, stop_next;
    logic [ROW_W-1:0]     rows_reg, rows_next;
    logic [31:0]          mask_reg, mask_next;
    logic                 oob_reg, oob_next;

    logic [8:0]           g_diff;
    logic                 code_ok;
    logic [GLYPH_AW-1:0]  g_in;
    logic [CURSOR_W-1:0]  add_b;
    logic [CURSOR_W-1:0]  sum;
    logic [CURSOR_W-1:0]  stop_val;
    logic [2:0]           w_field;
    logic [7:0]           cap_byte;
    logic [KW-1:0]        cap_lane;
    logic                 is_last;

    function automatic logic [7:0] bitrev8(input logic [7:0] b);
        logic [7:0] r;
        for (int j = 0; j < 8; j++) begin
            r[j] = |(b & (MSB_BIT >> j));
        end
        return r;
    endfunction

    assign g_diff  = {1'b0, in_item.char_code} - {1'b0, FIRST_CODE};
    assign code_ok = !g_diff[8] && (32'(g_diff) < GLYPH_COUNT);
    assign g_in    = GLYPH_AW'(g_diff);

    // The one shared adder: byte address during a fetch, row advance at emit.
    assign add_b = (state_reg == S_EMIT) ? CURSOR_W'(w_reg) : CURSOR_W'(k_reg);
    assign sum   = cursor_reg + add_b;

    assign w_field  = desc_rdata[14:12];
    assign stop_val = (32'(g_reg) == GLYPH_COUNT - 1) ? CURSOR_W'(bitmap_len)
                                                      : CURSOR_W'(desc_rdata[11:0]);
    assign cap_byte = oob_reg ? 8'h00 : bitrev8(byte_rdata);
    assign cap_lane = KW'(k_reg - KW'(1));
    assign is_last  = (sum >= stop_reg) || (rows_reg == ROW_W'(MAX_ROWS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        g_reg      <= g_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ink_reg    <= ink_next;
        w_reg      <= w_next;
        k_reg      <= k_next;
        cursor_reg <= cursor_next;
        stop_reg   <= stop_next;
        rows_reg   <= rows_next;
        mask_reg   <= mask_next;
        oob_reg    <= oob_next;
    end

    always_comb begin
        state_next  = state_reg;
        g_next      = g_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        ink_next    = ink_reg;
        w_next      = w_reg;
        k_next      = k_reg;
        cursor_next = cursor_reg;
        stop_next   = stop_reg;
        rows_next   = rows_reg;
        mask_next   = mask_reg;
        oob_next    = oob_reg;
        row_push    = 1'b0;
        idle        = (state_reg == S_IDLE);
        mem_rd.desc_raddr = g_reg;
        mem_rd.byte_raddr = BITMAP_AW'(sum);

        case (state_reg)
            S_IDLE: begin
                mem_rd.desc_raddr = g_in;
                if (in_accept && in_item.req_type == REQ_DRAW && code_ok) begin
                    g_next     = g_in;
                    px_next    = in_item.pos_x;
                    py_next    = in_item.pos_y;
                    ink_next   = in_item.ink_color;
                    state_next = S_DESC0;
                end
            end
            S_DESC0: begin
                if (32'(w_field) > MAX_WIDTH_BYTES) begin
                    w_next = KW'(MAX_WIDTH_BYTES);
                end else begin
                    w_next = KW'(w_field);
                end
                cursor_next = CURSOR_W'(desc_rdata[11:0]);
                // The last glyph has no successor; its end comes from bitmap_len.
                if (32'(g_reg) != GLYPH_COUNT - 1) begin
                    mem_rd.desc_raddr = GLYPH_AW'(g_reg + GLYPH_AW'(1));
                end
                state_next = S_DESC1;
            end
            S_DESC1: begin
                stop_next = stop_val;
                rows_next = '0;
                k_next    = '0;
                mask_next = '0;
                if (w_reg == '0 || !(cursor_reg < stop_val)) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                // Capture the byte issued last cycle while issuing the next one.
                if (k_reg != '0) begin
                    for (int i = 0; i < MASK_BYTES; i++) begin
                        if (cap_lane == KW'(i)) begin
                            mask_next[8*i +: 8] = cap_byte;
                        end
                    end
                end
                if (k_reg < w_reg) begin
                    oob_next = (32'(sum) >= BITMAP_BYTES);
                    k_next   = KW'(k_reg + KW'(1));
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    row_push = 1'b1;
                    if (is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cursor_next = sum;
                        rows_next   = ROW_W'(rows_reg + ROW_W'(1));
                        k_next      = '0;
                        mask_next   = '0;
                        state_next  = S_FETCH;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign row.row_x       = px_reg;
    assign row.row_y       = py_reg + 11'(rows_reg);
    assign row.pixel_mask  = mask_reg;
    assign row.pixel_color = ink_reg;
    assign row.last_row    = is_last;

`ifndef SYNTH
    a_k_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (k_reg <= w_reg))
        else $error("byte counter ran past the row width");

    a_width_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (w_reg != '0 && 32'(w_reg) <= MAX_WIDTH_BYTES))
        else $error("fetching a row of invalid width");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_push && row.last_row) |=> (state_reg == S_IDLE))
        else $error("sequencer kept running after the last row");

    a_rows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_push && !row.last_row) |=> (rows_reg == ROW_W'($past(rows_reg) + 1)))
        else $error("row counter did not advance by one");
`endif

endmodule

[hw/rtl/bitmap_glyph_row_renderer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_glyph_row_renderer
// Variable-width bitmap font renderer that emits one result per glyph row.
// ----------------------------------------------------------------------------
// Usage:
//   Input items on s_valid/s_ready/s_item either load a glyph descriptor,
//   load one bitmap byte, or draw a character. Loads produce nothing. A
//   draw produces one result per glyph row on m_valid/m_ready/m_item,
//   top row first, with last_row on the final one.
//   bitmap_len is written over the APB port, register word 0.
// Sequence:
//   A draw reads the glyph's descriptor and the next one (bitmap_len gives
//   the end of the last glyph), then reads each row of w bytes, w being the
//   saturated row width, through the bitmap memory read port, which serves
//   one byte per cycle, and hands the row to the output register. s_ready
//   is high only while no draw is running.
// Reset and stall:
//   aresetn clears the sequencer, the output valid and bitmap_len. The font
//   memories are not cleared and must be loaded before use. When the
//   receiver stalls, the row waits in the output register and the sequencer
//   holds before the next row.
// ----------------------------------------------------------------------------
module bitmap_glyph_row_renderer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bgr_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bgr_pkg::out_item_t  m_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bgr_pkg::*;

    logic [LEN_W-1:0]  bitmap_len_reg, bitmap_len_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;

    logic              in_accept;
    logic              seq_idle;
    logic              out_free;
    logic              row_push;
    out_item_t         row;
    mem_rd_t           mem_rd;
    logic              desc_we;
    logic              byte_we;
    logic [DESC_W-1:0] desc_rdata;
    logic [7:0]        byte_rdata;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_BITMAP_LEN);
    assign prdata    = (paddr[2] == REG_BITMAP_LEN) ? 32'(bitmap_len_reg) : 32'h0;

    assign s_ready   = seq_idle;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign desc_we = in_accept && (s_item.req_type == REQ_LOAD_DESC)
                     && (32'(s_item.load_index) < GLYPH_COUNT);
    assign byte_we = in_accept && (s_item.req_type == REQ_LOAD_BYTE)
                     && (32'(s_item.load_index) < BITMAP_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitmap_len_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            bitmap_len_reg <= bitmap_len_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    always_comb begin
        bitmap_len_next = bitmap_len_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        if (cfg_write) begin
            bitmap_len_next = pwdata[LEN_W-1:0];
        end
        if (row_push) begin
            m_valid_next = 1'b1;
            m_item_next  = row;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    bgr_ram #(
        .DW    (DESC_W),
        .DEPTH (GLYPH_COUNT)
    ) u_desc_ram (
        .aclk  (aclk),
        .we    (desc_we),
        .waddr (GLYPH_AW'(s_item.load_index)),
        .wdata ({s_item.glyph_width_bytes, s_item.load_value}),
        .raddr (mem_rd.desc_raddr),
        .rdata (desc_rdata)
    );

    bgr_ram #(
        .DW    (8),
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap_ram (
        .aclk  (aclk),
        .we    (byte_we),
        .waddr (BITMAP_AW'(s_item.load_index)),
        .wdata (s_item.load_value[7:0]),
        .raddr (mem_rd.byte_raddr),
        .rdata (byte_rdata)
    );

    bgr_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_item    (s_item),
        .bitmap_len (bitmap_len_reg),
        .desc_rdata (desc_rdata),
        .byte_rdata (byte_rdata),
        .out_free   (out_free),
        .mem_rd     (mem_rd),
        .idle       (seq_idle),
        .row_push   (row_push),
        .row        (row)
    );

endmodule

[tb/glyph_row_sb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_row_sb_pkg
// Scoreboard for the glyph row renderer: keeps its own copy of the font
// tables and of bitmap_len, predicts the rows of every draw item and checks
// each row that the block hands out against the oldest prediction.
// ----------------------------------------------------------------------------
package glyph_row_sb_pkg;

    import bgr_pkg::*;

    class glyph_row_scoreboard;

        bit [2:0]  glyph_w    [GLYPH_COUNT];
        bit [11:0] glyph_off  [GLYPH_COUNT];
        bit [7:0]  font_bytes [BITMAP_BYTES];
        int        font_len;
        out_item_t rows_due   [$];
        int        errors;

        function void set_len(int value);
            font_len = value;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        // Addresses past the end of the store read as zero.
        function bit [7:0] byte_at(int addr);
            if (addr >= BITMAP_BYTES) begin
                return 8'h00;
            end
            return font_bytes[addr];
        endfunction

        // Start offset, saturated row width and row count of glyph g.
        function void glyph_span(input int g, output int base, output int wid,
                                 output int rows);
            int stop;
            wid = glyph_w[g];
            if (wid > MAX_WIDTH_BYTES) begin
                wid = MAX_WIDTH_BYTES;
            end
            base = glyph_off[g];
            stop = (g == GLYPH_COUNT - 1) ? font_len : int'(glyph_off[g + 1]);
            rows = 0;
            if (wid != 0) begin
                for (int p = base; p < stop && rows < MAX_ROWS; p += wid) begin
                    rows++;
                end
            end
        endfunction

        function void note_item(in_item_t it);
            int        g, base, wid, rows;
            bit [7:0]  b;
            bit [31:0] mask;
            out_item_t r;
            case (req_t'(it.req_type))
                REQ_LOAD_DESC: begin
                    if (it.load_index < GLYPH_COUNT) begin
                        glyph_w[it.load_index]   = it.glyph_width_bytes;
                        glyph_off[it.load_index] = it.load_value;
                    end
                end
                REQ_LOAD_BYTE: begin
                    if (it.load_index < BITMAP_BYTES) begin
                        font_bytes[it.load_index] = it.load_value[7:0];
                    end
                end
                REQ_DRAW: begin
                    if (it.char_code < FIRST_CODE) begin
                        return;
                    end
                    g = it.char_code - FIRST_CODE;
                    if (g >= GLYPH_COUNT) begin
                        return;
                    end
                    glyph_span(g, base, wid, rows);
                    for (int n = 0; n < rows; n++) begin
                        mask = '0;
                        for (int k = 0; k < wid; k++) begin
                            b = byte_at(base + n * wid + k);
                            // The MSB of each byte is the leftmost pixel.
                            for (int j = 0; j < 8; j++) begin
                                mask[8 * k + j] = ((b & (MSB_BIT >> j)) != 0);
                            end
                        end
                        r.row_x       = it.pos_x;
                        r.row_y       = it.pos_y + 11'(n);
                        r.pixel_mask  = mask;
                        r.pixel_color = it.ink_color;
                        r.last_row    = (n == rows - 1);
                        rows_due.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_row(out_item_t got);
            out_item_t want;
            if (rows_due.size() == 0) begin
                $error("row item with none expected: x=%0d y=%0d mask=0x%0h",
                       got.row_x, got.row_y, got.pixel_mask);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            compare_field("row_x", want.row_x, got.row_x);
            compare_field("row_y", want.row_y, got.row_y);
            compare_field("pixel_mask", want.pixel_mask, got.pixel_mask);
            compare_field("pixel_color", want.pixel_color, got.pixel_color);
            compare_field("last_row", want.last_row, got.last_row);
        endfunction

    endclass

endpackage

[tb/bitmap_glyph_row_renderer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_glyph_row_renderer_tb
// Loads glyph descriptors and bitmap bytes, draws characters and checks the
// emitted rows. A short directed part covers the corner cases, then random
// glyph build-and-draw sequences mixed with stray items run under several
// bitmap_len settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module bitmap_glyph_row_renderer_tb;

    import bgr_pkg::*;
    import glyph_row_sb_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 4000;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 25;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    glyph_row_scoreboard sb = new();

    bit desc_loaded [GLYPH_COUNT];
    bit byte_loaded [BITMAP_BYTES];
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int font_items;
    int quiet_cycles;
    int len_plan [PHASES];
    int budget;
    int pick;

    bitmap_glyph_row_renderer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Random bursts of output stalls while stalls_on is set.
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_item(s_item);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_row(m_item);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic in_item_t random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    // Mostly random bytes, sometimes edge patterns; the upper nibble of the
    // value is noise that the block must drop.
    function automatic int font_byte();
        int b;
        case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = 8'h80;
            3:       b = 8'h01;
            default: b = $urandom_range(0, 255);
        endcase
        return ($urandom_range(0, 15) << 8) | b;
    endfunction

    // Called and returns at a falling edge.
    task automatic send_item(in_item_t it, bit effective);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_item  = it;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (effective) begin
            font_items++;
        end
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic load_desc(int idx, int wid, int off);
        in_item_t it;
        it                   = random_item();
        it.req_type          = REQ_LOAD_DESC;
        it.load_index        = 12'(idx);
        it.glyph_width_bytes = 3'(wid);
        it.load_value        = 12'(off);
        send_item(it, idx < GLYPH_COUNT);
        if (idx < GLYPH_COUNT) begin
            desc_loaded[idx] = 1'b1;
        end
    endtask

    task automatic load_byte(int addr, int value);
        in_item_t it;
        it            = random_item();
        it.req_type   = REQ_LOAD_BYTE;
        it.load_index = 12'(addr);
        it.load_value = 12'(value);
        send_item(it, 1'b1);
        byte_loaded[addr] = 1'b1;
    endtask

    task automatic draw_glyph(int code, int px, int py, int ink);
        in_item_t it;
        it           = random_item();
        it.req_type  = REQ_DRAW;
        it.char_code = 8'(code);
        it.pos_x     = 11'(px);
        it.pos_y     = 11'(py);
        it.ink_color = 8'(ink);
        send_item(it, code >= FIRST_CODE && code < FIRST_CODE + GLYPH_COUNT);
    endtask

    // A draw may only touch descriptors and bytes that were loaded.
    function automatic bit glyph_ready(int g);
        int base, wid, rows;
        if (!desc_loaded[g]) begin
            return 1'b0;
        end
        if (g < GLYPH_COUNT - 1 && !desc_loaded[g + 1]) begin
            return 1'b0;
        end
        sb.glyph_span(g, base, wid, rows);
        for (int a = base; a < base + rows * wid; a++) begin
            if (a < BITMAP_BYTES && !byte_loaded[a]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic fill_glyph_bytes(int g);
        int base, wid, rows;
        sb.glyph_span(g, base, wid, rows);
        for (int a = base; a < base + rows * wid && a < BITMAP_BYTES; a++) begin
            if (!byte_loaded[a] || $urandom_range(0, 7) == 0) begin
                load_byte(a, font_byte());
            end
        end
    endtask

    // Builds one glyph (descriptor, end bound, bytes) and draws it.
    task automatic glyph_sequence();
        int g, wraw, weff, n, span, base, stop;
        g = ($urandom_range(0, 5) == 0) ? GLYPH_COUNT - 1 : $urandom_range(0, GLYPH_COUNT - 2);
        case ($urandom_range(0, 15))
            0:       wraw = 0;
            1, 2:    wraw = $urandom_range(MAX_WIDTH_BYTES + 1, 7);
            default: wraw = $urandom_range(1, MAX_WIDTH_BYTES);
        endcase
        weff = (wraw > MAX_WIDTH_BYTES) ? MAX_WIDTH_BYTES : ((wraw == 0) ? 1 : wraw);
        n    = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
        // Leaving the last row partly outside the glyph is allowed.
        span = n * weff - $urandom_range(0, weff - 1);
        if (g < GLYPH_COUNT - 1) begin
            base = ($urandom_range(0, 7) == 0) ? (BITMAP_BYTES - 1) - span
                                                : $urandom_range(0, 300);
            stop = base + span;
            if ($urandom_range(0, 9) == 0) begin
                stop = $urandom_range(0, base);
            end
            load_desc(g, wraw, base);
            load_desc(g + 1, $urandom_range(0, 7), stop);
        end else begin
            base = sb.font_len - span;
            if (base < 0) begin
                base = 0;
            end
            if (base > BITMAP_BYTES - 1) begin
                base = BITMAP_BYTES - 1;
            end
            if ($urandom_range(0, 9) == 0 && sb.font_len < BITMAP_BYTES) begin
                base = $urandom_range(sb.font_len, BITMAP_BYTES - 1);
            end
            load_desc(g, wraw, base);
        end
        fill_glyph_bytes(g);
        draw_glyph(g + FIRST_CODE, $urandom_range(0, 2047), $urandom_range(0, 2047),
                   $urandom_range(0, 255));
    endtask

    task automatic stray_item();
        in_item_t it;
        int       g;
        it = random_item();
        case ($urandom_range(0, 5))
            0: begin
                it.req_type = REQ_UNUSED;
                send_item(it, 1'b0);
            end
            1: load_desc($urandom_range(GLYPH_COUNT, 4095), $urandom_range(0, 7),
                         $urandom_range(0, 4095));
            2: load_byte($urandom_range(0, BITMAP_BYTES - 1), $urandom_range(0, 4095));
            3: begin
                it.req_type  = REQ_DRAW;
                it.char_code = 8'(($urandom_range(0, 1) == 0)
                                  ? $urandom_range(0, FIRST_CODE - 1)
                                  : $urandom_range(FIRST_CODE + GLYPH_COUNT, 255));
                send_item(it, 1'b0);
            end
            4: begin
                g = $urandom_range(0, GLYPH_COUNT - 1);
                if (glyph_ready(g)) begin
                    draw_glyph(g + FIRST_CODE, it.pos_x, it.pos_y, it.ink_color);
                end else begin
                    it.req_type  = REQ_DRAW;
                    it.char_code = 8'($urandom_range(0, FIRST_CODE - 1));
                    send_item(it, 1'b0);
                end
            end
            default: load_desc($urandom_range(0, GLYPH_COUNT - 1), $urandom_range(0, 7),
                               $urandom_range(0, 4095));
        endcase
    endtask

    // Waits for all predicted rows, then lets a draw without rows finish.
    task automatic drain_rows(int extra);
        while (sb.pending() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_bitmap_len(int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_BITMAP_LEN, 2'b00};
        pwdata  = 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_len(value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        font_items   = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_bitmap_len(BITMAP_BYTES);

        // Directed: edge byte patterns, a wide glyph with a partial last row,
        // a narrow glyph, a zero-width glyph, an empty glyph, and the last
        // glyph reading past the end of the store.
        load_byte(0, 8'h80);
        load_byte(1, 8'h01);
        load_byte(2, 8'hFF);
        load_byte(3, 8'h00);
        load_byte(4, 8'hA5);
        load_byte(5, 8'h5A);
        load_byte(6, 8'h3C);
        load_byte(7, 8'hC3);
        load_byte(4094, 8'h81);
        load_byte(4095, 12'hFFF);
        load_desc(0, 7, 0);
        load_desc(1, 1, 6);
        load_desc(2, 0, 8);
        load_desc(3, 3, 8);
        load_desc(4, 1, 8);
        load_desc(GLYPH_COUNT - 1, 4, 4094);
        load_desc(GLYPH_COUNT, 2, 5);
        load_desc(4095, 7, 12'hFFF);
        s_item          = random_item();
        s_item.req_type = REQ_UNUSED;
        send_item(s_item, 1'b0);
        draw_glyph(FIRST_CODE, 2047, 2047, 255);
        draw_glyph(FIRST_CODE + 1, 0, 0, 0);
        draw_glyph(FIRST_CODE + 2, 100, 200, 17);
        draw_glyph(FIRST_CODE + 3, 5, 6, 7);
        draw_glyph(FIRST_CODE - 1, 1, 2, 3);
        draw_glyph(FIRST_CODE + GLYPH_COUNT, 1, 2, 3);
        draw_glyph(255, 1, 2, 3);
        draw_glyph(FIRST_CODE + GLYPH_COUNT - 1, 1024, 2040, 128);

        len_plan = '{0, 1, 4095, 0, BITMAP_BYTES, 0};
        len_plan[3] = $urandom_range(2, 4094);
        len_plan[5] = $urandom_range(2, BITMAP_BYTES);
        for (int p = 0; p < PHASES; p++) begin
            drain_rows(20);
            write_bitmap_len(len_plan[p]);
            if (p == PHASES - 1) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            budget = font_items + PHASE_ITEMS;
            while (font_items < budget) begin
                if (p < PHASES - 1) begin
                    gaps_on   = ($urandom_range(0, 4) != 0);
                    stalls_on = ($urandom_range(0, 4) != 0);
                end
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    drain_rows(0);
                end else if (pick < 6) begin
                    stray_item();
                end else begin
                    glyph_sequence();
                end
            end
        end
        s_valid = 1'b0;

        drain_rows(0);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
